### sv/console_line_editor_unit_assert.svh
// ----------------------------------------------------------------------------
// console line editor assertion macros
// concurrent checks clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CLE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// word types, key codes and result kinds of the console line editor
// ----------------------------------------------------------------------------
package cle_pkg;

  // default ring depth
  localparam int BUF_DEPTH_DEF = 128;

  // request types
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_ECHO  = 3'd1;
  localparam logic [2:0] KIND_ERASE = 3'd2;
  localparam logic [2:0] KIND_DUMP  = 3'd3;
  localparam logic [2:0] KIND_DATA  = 3'd4;
  localparam logic [2:0] KIND_EMPTY = 3'd5;
  localparam logic [2:0] KIND_EOF   = 3'd6;

  // key codes
  localparam logic [7:0] KEY_NUL   = 8'h00;
  localparam logic [7:0] KEY_CTL_C = 8'h03;
  localparam logic [7:0] KEY_CTL_D = 8'h04;
  localparam logic [7:0] KEY_CTL_H = 8'h08;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_CTL_P = 8'h10;
  localparam logic [7:0] KEY_CTL_U = 8'h15;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_HIST0 = 8'hE2;
  localparam logic [7:0] KEY_HIST1 = 8'hE3;
  localparam logic [7:0] KEY_HIST2 = 8'hE6;
  localparam logic [7:0] KEY_HIST3 = 8'hE7;

  // request word
  typedef struct packed {
    logic       req_type;
    logic [7:0] key_byte;
    logic       read_started;
  } cle_req_t;

  // result word
  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] out_byte;
    logic [7:0] erase_count;
    logic       line_committed;
    logic       read_done;
  } cle_rsp_t;

endpackage

### sv/console_line_editor_unit.sv
// Path: a word passes S_EXEC then S_DONE, which sets rsp_valid once the output register is free.
// One word at a time; ^U adds S_KILL_TEST, then S_KILL_FETCH and S_KILL_TEST again per erased byte.
// The kill-line walk is bounded by the single store read port, one byte back per read.
// A finished result waits in the output register while the next word is taken.
// Reset: read, commit and edit indices clear to zero; the line store is not cleared.
// ----------------------------------------------------------------------------
// console_line_editor_unit
// canonical-mode console line buffer: ring store with read, commit and edit
// indices, keystroke editing and one-byte reads under a small sequencer
// ----------------------------------------------------------------------------
`include "console_line_editor_unit_assert.svh"

module console_line_editor_unit #(
  parameter int BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cle_pkg::cle_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cle_pkg::cle_rsp_t rsp
);
  import cle_pkg::*;

  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam int IDX_W  = SLOT_W + 1;
  localparam logic [IDX_W:0]   IDX_MOD  = (IDX_W + 1)'(2 * BUF_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(2 * BUF_DEPTH - 1);
  localparam logic [IDX_W-1:0] DEPTH_I  = IDX_W'(BUF_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_KILL_FETCH,
    S_KILL_TEST,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    KC_DUMP,
    KC_KILL,
    KC_ERASE,
    KC_IGNORE,
    KC_STORE
  } key_cls_t;

  // index arithmetic modulo twice the depth
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_LAST) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_LAST : a - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_diff(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] t;
    t = {1'b0, a} + IDX_MOD - {1'b0, b};
    if (t >= IDX_MOD) t = t - IDX_MOD;
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] s;
    s = (a >= DEPTH_I) ? a - DEPTH_I : a;
    return s[SLOT_W-1:0];
  endfunction

  state_t            state;
  cle_req_t          cur;
  cle_rsp_t          res;
  logic [IDX_W-1:0]  read_idx;
  logic [IDX_W-1:0]  commit_idx;
  logic [IDX_W-1:0]  edit_idx;
  logic [IDX_W-1:0]  cnt;

  logic [7:0]        mem [BUF_DEPTH];
  logic [7:0]        rd_data;
  logic [SLOT_W-1:0] mem_raddr;
  logic              mem_we;
  logic [7:0]        store_byte;

  logic [IDX_W-1:0]  fill_cnt;
  logic [IDX_W-1:0]  line_cnt;
  logic [IDX_W-1:0]  edit_inc;
  logic              ring_full;
  logic              commit_now;
  key_cls_t          key_cls;

  assign req_ready  = (state == S_IDLE);
  assign fill_cnt   = idx_diff(edit_idx, read_idx);
  assign line_cnt   = idx_diff(commit_idx, read_idx);
  assign edit_inc   = idx_inc(edit_idx);
  assign ring_full  = (fill_cnt >= DEPTH_I);
  assign store_byte = (cur.key_byte == KEY_CR) ? KEY_LF : cur.key_byte;
  assign commit_now = (store_byte == KEY_LF) || (store_byte == KEY_CTL_D) ||
                      (store_byte == KEY_CTL_C) ||
                      (idx_diff(edit_inc, read_idx) == DEPTH_I);

  // keystroke classification
  always_comb begin
    case (cur.key_byte)
      KEY_CTL_P: key_cls = KC_DUMP;
      KEY_CTL_U: key_cls = KC_KILL;
      KEY_CTL_H, KEY_DEL: key_cls = KC_ERASE;
      KEY_ESC, KEY_HIST0, KEY_HIST1, KEY_HIST2, KEY_HIST3: key_cls = KC_IGNORE;
      default: key_cls = (cur.key_byte == KEY_NUL || ring_full) ? KC_IGNORE : KC_STORE;
    endcase
  end

  // store read address: read slot for a read, byte behind the edit point otherwise
  always_comb begin
    case (state)
      S_IDLE:  mem_raddr = (req.req_type == REQ_READ) ? slot_of(read_idx)
                                                      : slot_of(idx_dec(edit_idx));
      default: mem_raddr = slot_of(idx_dec(edit_idx));
    endcase
  end

  assign mem_we = (state == S_EXEC) && (cur.req_type == REQ_KEY) && (key_cls == KC_STORE);

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[slot_of(edit_idx)] <= store_byte;
    rd_data <= mem[mem_raddr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      read_idx   <= '0;
      commit_idx <= '0;
      edit_idx   <= '0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_DONE)) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= ((cur.req_type == REQ_KEY) && (key_cls == KC_KILL)) ? S_KILL_TEST : S_DONE;
          if (cur.req_type == REQ_READ) begin
            // pop one committed byte, if any; an end-of-file byte stays for a read already started
            if (read_idx == commit_idx) begin
              res <= '{KIND_EMPTY, 8'h00, 8'h00, 1'b0, 1'b0};
            end else if (rd_data == KEY_CTL_D) begin
              if (!cur.read_started) read_idx <= idx_inc(read_idx);
              res <= '{KIND_EOF, 8'h00, 8'h00, 1'b0, 1'b0};
            end else begin
              read_idx <= idx_inc(read_idx);
              res      <= '{KIND_DATA, rd_data, 8'h00, 1'b0, (rd_data == KEY_LF)};
            end
          end else begin
            case (key_cls)
              KC_DUMP: res <= '{KIND_DUMP, 8'h00, 8'h00, 1'b0, 1'b0};
              KC_KILL: cnt <= '0;
              KC_ERASE: begin
                if (edit_idx != commit_idx) begin
                  edit_idx <= idx_dec(edit_idx);
                  res      <= '{KIND_ERASE, 8'h00, 8'd1, 1'b0, 1'b0};
                end else begin
                  res      <= '{KIND_ERASE, 8'h00, 8'h00, 1'b0, 1'b0};
                end
              end
              KC_STORE: begin
                edit_idx <= edit_inc;
                if (commit_now) commit_idx <= edit_inc;
                res      <= '{KIND_ECHO, store_byte, 8'h00, commit_now, 1'b0};
              end
              default: res <= '{KIND_NONE, 8'h00, 8'h00, 1'b0, 1'b0};
            endcase
          end
        end
        S_KILL_FETCH: begin
          state <= S_KILL_TEST;
        end
        S_KILL_TEST: begin
          // walk back one byte per read until commit point or stored newline
          if (edit_idx != commit_idx && rd_data != KEY_LF) begin
            edit_idx <= idx_dec(edit_idx);
            cnt      <= cnt + IDX_W'(1);
            state    <= S_KILL_FETCH;
          end else begin
            res   <= '{KIND_ERASE, 8'h00, 8'(cnt), 1'b0, 1'b0};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CLE_ASSERT_ALWAYS(a_ring_order, (line_cnt <= fill_cnt) && (fill_cnt <= DEPTH_I),
                     "ring indices out of order")
  `CLE_ASSERT_IMPLY(a_count_kind, rsp_valid && (rsp.result_kind != KIND_ERASE),
                    rsp.erase_count == 8'd0, "erase count on non-erase word")
  `CLE_ASSERT_IMPLY(a_commit_kind, rsp_valid && rsp.line_committed,
                    rsp.result_kind == KIND_ECHO, "commit flag without echo")

endmodule

### tb/sv/console_line_editor_unit_test.sv
// ----------------------------------------------------------------------------
// console_line_editor_unit_test
// drives keystroke and read words into the line editor under several idling and
// stall phases, predicts each result word from a local copy of the ring and its
// indices or the directed table, compares it field by field in arrival order
// ----------------------------------------------------------------------------
module console_line_editor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int PHASE_ITEMS    = 300;
  localparam int MAX_REPORTS    = 10;

  localparam logic [20:0] UNCHECKED = '0;

  // one row of the directed table
  typedef struct packed {
    cle_req_t w;
    logic     chk;
    cle_rsp_t exp;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  cle_req_t req;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  cle_rsp_t rsp;

  // local copy of the ring and its indices
  logic [7:0] line_mem [128];
  logic [7:0] rd_ix;
  logic [7:0] cm_ix;
  logic [7:0] ed_ix;

  cle_rsp_t   rsp_due [$];
  int         faults = 0;
  int         live_items;
  int         idle_pct;
  int         stall_pct;
  int         quiet_cycles = 0;

  int         phase_idle  [4] = '{0, 78, 0, 36};
  int         phase_stall [4] = '{0, 0, 78, 36};

  // directed words: extremes, every key class and the special cases
  dir_row_t dir_tab [26] = '{
    {REQ_READ, 8'h00,     1'b0, 1'b1, KIND_EMPTY, 8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_CTL_P, 1'b0, 1'b1, KIND_DUMP,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_NUL,   1'b0, 1'b1, KIND_NONE,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_ESC,   1'b0, 1'b1, KIND_NONE,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_HIST0, 1'b0, 1'b1, KIND_NONE,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_HIST1, 1'b0, 1'b1, KIND_NONE,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_HIST2, 1'b0, 1'b1, KIND_NONE,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_HIST3, 1'b0, 1'b1, KIND_NONE,  8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_CTL_H, 1'b1, 1'b1, KIND_ERASE, 8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_DEL,   1'b0, 1'b1, KIND_ERASE, 8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_CTL_U, 1'b0, 1'b1, KIND_ERASE, 8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  8'h01,     1'b0, 1'b1, KIND_ECHO,  8'h01,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  8'hFF,     1'b1, 1'b1, KIND_ECHO,  8'hFF,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_DEL,   1'b0, 1'b0, UNCHECKED},
    {REQ_KEY,  8'h61,     1'b0, 1'b1, KIND_ECHO,  8'h61,     8'h00, 1'b0, 1'b0},
    {REQ_KEY,  KEY_CTL_U, 1'b0, 1'b0, UNCHECKED},
    {REQ_KEY,  8'h78,     1'b0, 1'b0, UNCHECKED},
    {REQ_KEY,  KEY_CR,    1'b0, 1'b1, KIND_ECHO,  KEY_LF,    8'h00, 1'b1, 1'b0},
    {REQ_READ, 8'hFF,     1'b1, 1'b0, UNCHECKED},
    {REQ_READ, 8'h00,     1'b0, 1'b1, KIND_DATA,  KEY_LF,    8'h00, 1'b0, 1'b1},
    {REQ_KEY,  KEY_CTL_C, 1'b0, 1'b1, KIND_ECHO,  KEY_CTL_C, 8'h00, 1'b1, 1'b0},
    {REQ_READ, 8'h00,     1'b0, 1'b0, UNCHECKED},
    {REQ_KEY,  KEY_CTL_D, 1'b0, 1'b1, KIND_ECHO,  KEY_CTL_D, 8'h00, 1'b1, 1'b0},
    {REQ_READ, 8'h00,     1'b1, 1'b1, KIND_EOF,   8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_READ, 8'h00,     1'b0, 1'b1, KIND_EOF,   8'h00,     8'h00, 1'b0, 1'b0},
    {REQ_READ, 8'h00,     1'b0, 1'b1, KIND_EMPTY, 8'h00,     8'h00, 1'b0, 1'b0}
  };

  console_line_editor_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always #5 clk = ~clk;

  // editing of one word against the local ring, giving its result word
  function automatic cle_rsp_t edit_step(cle_req_t w);
    cle_rsp_t   r;
    logic [7:0] c;
    logic [7:0] prev;
    logic [7:0] fill;
    logic [7:0] cnt;
    r   = '0;
    cnt = 8'd0;
    if (w.req_type == REQ_KEY) begin
      c    = w.key_byte;
      fill = ed_ix - rd_ix;
      if (c == KEY_CTL_P) begin
        r.result_kind = KIND_DUMP;
      end else if (c == KEY_CTL_U) begin
        // walk back to the commit point or a stored newline
        prev = ed_ix - 8'd1;
        while (ed_ix != cm_ix && line_mem[prev[6:0]] != KEY_LF) begin
          ed_ix = prev;
          prev  = ed_ix - 8'd1;
          cnt   = cnt + 8'd1;
        end
        r.result_kind = KIND_ERASE;
        r.erase_count = cnt;
      end else if (c == KEY_CTL_H || c == KEY_DEL) begin
        if (ed_ix != cm_ix) begin
          ed_ix = ed_ix - 8'd1;
          cnt   = 8'd1;
        end
        r.result_kind = KIND_ERASE;
        r.erase_count = cnt;
      end else if (c == KEY_ESC || c == KEY_HIST0 || c == KEY_HIST1 ||
                   c == KEY_HIST2 || c == KEY_HIST3 || c == KEY_NUL ||
                   fill >= 8'd128) begin
        r.result_kind = KIND_NONE;
      end else begin
        if (c == KEY_CR) c = KEY_LF;
        line_mem[ed_ix[6:0]] = c;
        ed_ix = ed_ix + 8'd1;
        fill  = ed_ix - rd_ix;
        r.result_kind = KIND_ECHO;
        r.out_byte    = c;
        if (c == KEY_LF || c == KEY_CTL_D || c == KEY_CTL_C || fill == 8'd128) begin
          cm_ix = ed_ix;
          r.line_committed = 1'b1;
        end
      end
    end else begin
      if (rd_ix == cm_ix) begin
        r.result_kind = KIND_EMPTY;
      end else begin
        c = line_mem[rd_ix[6:0]];
        if (c == KEY_CTL_D) begin
          // end of file stays put when the read already delivered bytes
          if (!w.read_started) rd_ix = rd_ix + 8'd1;
          r.result_kind = KIND_EOF;
        end else begin
          rd_ix = rd_ix + 8'd1;
          r.result_kind = KIND_DATA;
          r.out_byte    = c;
          r.read_done   = (c == KEY_LF);
        end
      end
    end
    return r;
  endfunction

  // a byte that is simply stored and echoed
  function automatic logic [7:0] plain_key();
    logic [7:0] k;
    logic       retry;
    do begin
      if ($urandom_range(0, 3) != 0) k = 8'($urandom_range(8'h20, 8'h7E));
      else k = 8'($urandom_range(1, 255));
      case (k)
        KEY_NUL, KEY_CTL_C, KEY_CTL_D, KEY_CTL_H, KEY_LF, KEY_CR, KEY_CTL_P,
        KEY_CTL_U, KEY_ESC, KEY_DEL, KEY_HIST0, KEY_HIST1, KEY_HIST2,
        KEY_HIST3: retry = 1'b1;
        default:   retry = 1'b0;
      endcase
    end while (retry);
    return k;
  endfunction

  function automatic logic [7:0] commit_key();
    case ($urandom_range(0, 3))
      0:       return KEY_LF;
      1:       return KEY_CR;
      2:       return KEY_CTL_C;
      default: return KEY_CTL_D;
    endcase
  endfunction

  function automatic cle_req_t key_w(logic [7:0] k);
    cle_req_t w;
    w = {REQ_KEY, k, 1'($urandom_range(0, 1))};
    return w;
  endfunction

  function automatic cle_req_t read_w(logic started);
    cle_req_t w;
    w = {REQ_READ, 8'($urandom), started};
    return w;
  endfunction

  // offer one word, wait for it to be taken, then note its result
  task automatic put_word(cle_req_t w, logic chk, cle_rsp_t exp);
    cle_rsp_t r;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    r = edit_step(w);
    rsp_due.push_back(chk ? exp : r);
    live_items++;
  endtask

  // one random burst of words, mostly well-formed editing sessions
  task automatic random_chunk();
    int pick;
    int sub;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // a typed line with edits, a commit key and often a drain
      n = $urandom_range(0, 12);
      repeat (n) begin
        sub = $urandom_range(0, 99);
        if (sub < 10) put_word(key_w($urandom_range(0, 1) ? KEY_CTL_H : KEY_DEL), 1'b0, '0);
        else if (sub < 14) put_word(key_w(KEY_CTL_U), 1'b0, '0);
        else if (sub < 17) put_word(key_w(KEY_CTL_P), 1'b0, '0);
        else put_word(key_w(plain_key()), 1'b0, '0);
      end
      put_word(key_w(commit_key()), 1'b0, '0);
      if ($urandom_range(0, 1) != 0) begin
        repeat (n + 2) put_word(read_w(1'($urandom_range(0, 1))), 1'b0, '0);
      end
    end else if (pick < 65) begin
      // reader drains a few bytes
      repeat ($urandom_range(1, 8)) put_word(read_w(1'($urandom_range(0, 1))), 1'b0, '0);
    end else if (pick < 80) begin
      // noise: any word at all
      repeat ($urandom_range(1, 6)) put_word(cle_req_t'(10'($urandom)), 1'b0, '0);
    end else if (pick < 92) begin
      // end of file, seen again by a read that already delivered bytes
      repeat ($urandom_range(0, 3)) put_word(key_w(plain_key()), 1'b0, '0);
      put_word(key_w(KEY_CTL_D), 1'b0, '0);
      repeat ($urandom_range(0, 4)) put_word(read_w(1'b1), 1'b0, '0);
      repeat ($urandom_range(1, 3)) put_word(read_w(1'b0), 1'b0, '0);
    end else begin
      // long line that may fill the ring, ended by a kill, a commit key or an erase
      repeat ($urandom_range(60, 140)) put_word(key_w(plain_key()), 1'b0, '0);
      case ($urandom_range(0, 2))
        0:       put_word(key_w(KEY_CTL_U), 1'b0, '0);
        1:       put_word(key_w(commit_key()), 1'b0, '0);
        default: put_word(key_w(KEY_CTL_H), 1'b0, '0);
      endcase
    end
  endtask

  task automatic note_fault(string what, cle_rsp_t exp, cle_rsp_t got);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("%s: exp kind %0d byte %h cnt %0d com %b done %b",
               what, exp.result_kind, exp.out_byte, exp.erase_count, exp.line_committed,
               exp.read_done);
      $display("  got kind %0d byte %h cnt %0d com %b done %b",
               got.result_kind, got.out_byte, got.erase_count,
               got.line_committed, got.read_done);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    rsp_ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // result check against the oldest predicted word
  always @(posedge clk) begin
    cle_rsp_t exp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_due.size() == 0) begin
        note_fault("unexpected word", '0, rsp);
      end else begin
        exp = rsp_due.pop_front();
        if (rsp.result_kind != exp.result_kind || rsp.out_byte != exp.out_byte ||
            rsp.erase_count != exp.erase_count ||
            rsp.line_committed != exp.line_committed || rsp.read_done != exp.read_done) begin
          note_fault("mismatch", exp, rsp);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    live_items   = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    rd_ix        = 8'd0;
    cm_ix        = 8'd0;
    ed_ix        = 8'd0;
    foreach (line_mem[i]) line_mem[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) put_word(dir_tab[i].w, dir_tab[i].chk, dir_tab[i].exp);

    for (int ph = 0; ph < 4; ph++) begin
      // sender holds off until every result word is home
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clk);
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      while (live_items < (ph + 1) * PHASE_ITEMS) random_chunk();
    end
    req_valid <= 1'b0;

    while (rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rsp_due.size() != 0) begin
      $display("%0d result words never arrived", rsp_due.size());
    end
    if (faults == 0 && rsp_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/cle_pkg.sv
sv/console_line_editor_unit.sv
tb/sv/console_line_editor_unit_test.sv
